@@ hdl/gts_pkg.sv @@
`timescale 1ns / 1ps

package gts_pkg;

    // Field widths of the channels and registers.
    localparam int HASH_W     = 11;
    localparam int NSOL_W     = 13;
    localparam int TOTAL_W    = 11;
    localparam int THR_W      = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // Width of the measurement tag kept with every table entry.
    localparam int EPOCH_W = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_VARS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'd1;

    // Register reset values.
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1;
    localparam logic [THR_W-1:0]   THR_RESET   = 12'd72;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_PROBE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_PROBE      = 2'd0,
        STAT_FOUND      = 2'd1,
        STAT_EXHAUSTED  = 2'd2,
        STAT_IDLE_PROBE = 2'd3
    } t_status;

    // Per-count probe outcome held in the table.
    typedef enum logic [1:0] {
        PS_UNKNOWN = 2'd0,
        PS_BELOW   = 2'd1,
        PS_FULL    = 2'd2
    } t_pstat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_INIT,
        S_READ,
        S_EVAL,
        S_NEXT
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_cmd              command;
        logic [HASH_W-1:0] start_hash;
        logic              later_round;
        logic [NSOL_W-1:0] sol_cnt;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [HASH_W-1:0] probe_hash;
        logic [HASH_W-1:0] result_hash;
        logic [NSOL_W-1:0] result_count;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] wr_data;
    } t_cfg_wr;

endpackage

@@ hdl/gts_if.sv @@
`timescale 1ns / 1ps

// Input item channel.
interface gts_in_if;
    import gts_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Result item channel.
interface gts_out_if;
    import gts_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface gts_cfg_if;
    import gts_pkg::*;
    logic    valid;
    logic    ready;
    t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/gts_alu.sv @@
`timescale 1ns / 1ps

// Shared signed adder/subtractor, time-multiplexed by the sequencer.
module gts_alu #(
    parameter int W = 13
) (
    input  gts_pkg::t_alu_op     i_op,
    input  logic signed [W-1:0]  i_a,
    input  logic signed [W-1:0]  i_b,
    output logic signed [W-1:0]  o_y
);
    import gts_pkg::*;

    // One add or subtract per cycle.
    always_comb begin
        case (i_op)
            ALU_ADD: o_y = i_a + i_b;
            ALU_SUB: o_y = i_a - i_b;
            default: o_y = i_a + i_b;
        endcase
    end

endmodule

@@ hdl/gts_mem.sv @@
`timescale 1ns / 1ps

// Single write port, single registered read port table.
module gts_mem #(
    parameter int DEPTH = 1025,
    parameter int W     = 19,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    import gts_pkg::*;

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/galloping_threshold_search.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Transaction
// i_cfg     in         register write (index, data), always ready
// i_in      in         start a measurement, or deliver one probe result
// o_out     out        probe request, boundary found, exhausted, or idle probe
//
// A start passes the init step; a start with zero total answers directly from idle.
// Every fifteenth start with a nonzero total, counting from the first after
// reset, first clears all MAX_VARS+1 entries of the status table, one entry per cycle.
// A probe result runs the read and evaluate steps to a boundary answer, and adds
// the next step for a next probe or exhaustion; while inactive it gets an idle probe.
// The sequencer steps one shared adder and the registered table read port.
// Reset is synchronous, active low. The block takes a new input transaction only
// when idle and its result register is empty or being emptied.
module galloping_threshold_search #(
    parameter int MAX_VARS    = 1024,
    parameter int COUNT_WIDTH = 13
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gts_cfg_if.sink    i_cfg,
    gts_in_if.sink     i_in,
    gts_out_if.source  o_out
);
    import gts_pkg::*;

    localparam int HW    = $clog2(MAX_VARS + 1);
    localparam int IW    = (HW > HASH_W) ? HW : HASH_W;
    localparam int SW    = IW + 2;
    localparam int DEPTH = MAX_VARS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CSW   = (COUNT_WIDTH < NSOL_W) ? COUNT_WIDTH : NSOL_W;
    localparam int MW    = EPOCH_W + 2 + CSW;

    localparam logic [IW-1:0]         MAXV        = IW'(MAX_VARS);
    localparam logic [AW-1:0]         ADDR_LAST   = AW'(MAX_VARS);
    localparam logic [EPOCH_W-1:0]    EPOCH_LAST  = '1;
    localparam logic [EPOCH_W-1:0]    EPOCH_FIRST = EPOCH_W'(1);
    localparam logic signed [SW-1:0]  ONE_S       = SW'(1);
    localparam logic signed [SW-1:0]  TWO_S       = SW'(2);
    localparam logic signed [SW-1:0]  M1_S        = SW'(-1);
    localparam logic signed [SW-1:0]  M2_S        = SW'(-2);
    localparam logic signed [SW-1:0]  ZERO_S      = SW'(0);

    // Control registers.
    t_state               r_state, n_state;
    logic                 r_active, n_active;
    logic                 r_out_valid, n_out_valid;
    logic [EPOCH_W-1:0]   r_epoch, n_epoch;
    logic [TOTAL_W-1:0]   r_total_vars;
    logic [THR_W-1:0]     r_threshold;

    // Search registers.
    logic [AW-1:0]        r_sweep_addr, n_sweep_addr;
    logic                 r_later, n_later;
    logic [IW-1:0]        r_tot, n_tot;
    logic [NSOL_W-1:0]    r_full, n_full;
    logic [IW-1:0]        r_cur, n_cur;
    logic [IW-1:0]        r_prev, n_prev;
    logic [IW-1:0]        r_low, n_low;
    logic [IW-1:0]        r_high, n_high;
    logic [IW-1:0]        r_anchor, n_anchor;
    logic [NSOL_W-1:0]    r_n, n_n;
    logic                 r_below, n_below;
    logic                 r_ahead, n_ahead;
    logic                 r_near, n_near;
    logic                 r_more, n_more;
    logic signed [SW-1:0] r_t, n_t;
    t_out_item            r_out, n_out;

    // Handshakes and decoded inputs.
    logic                 in_acc;
    logic                 cfg_acc;
    logic                 out_free;
    logic [IW-1:0]        tot_c;
    logic [IW-1:0]        start_c;
    logic [NSOL_W-1:0]    sols_c;
    logic                 below_c;

    // Shared adder.
    t_alu_op              alu_op;
    logic signed [SW-1:0] alu_a, alu_b, alu_y;

    // Table port.
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [MW-1:0]        mem_wdata, mem_rdata;
    logic [EPOCH_W-1:0]   rd_tag;
    t_pstat               rd_stat;
    logic [CSW-1:0]       rd_cnt;
    logic                 rd_live;
    logic                 hit_below, hit_full;

    // Next-probe arithmetic.
    logic signed [SW-1:0] cur_s, low_s, high_s, tot_s;
    logic                 t_big, t_eq, mid_sel;
    logic signed [SW-1:0] next_raw;
    logic [IW-1:0]        next_cur;
    logic [IW-1:0]        prev_adj;

    gts_alu #(.W(SW)) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    gts_mem #(.DEPTH(DEPTH), .W(MW), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Handshakes.
    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && out_free;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Input decode: clamp the total, move an out-of-range start below the total, clamp the solution count.
    assign tot_c   = (IW'(r_total_vars) > MAXV) ? MAXV : IW'(r_total_vars);
    assign start_c = (IW'(i_in.data.start_hash) >= tot_c) ? alu_y[IW-1:0]
                                                          : IW'(i_in.data.start_hash);
    assign sols_c  = (i_in.data.sol_cnt > r_full) ? r_full : i_in.data.sol_cnt;
    assign below_c = i_in.data.sol_cnt < r_full;

    // Table entry fields; an entry is live only under the current tag.
    assign rd_tag  = mem_rdata[MW-1 -: EPOCH_W];
    assign rd_stat = t_pstat'(mem_rdata[CSW+1:CSW]);
    assign rd_cnt  = mem_rdata[CSW-1:0];
    assign rd_live = rd_tag == r_epoch;

    // Boundary detection against the neighboring count.
    assign hit_below = r_below && ((r_cur == '0) || (rd_live && rd_stat == PS_FULL));
    assign hit_full  = !r_below && r_ahead && rd_live && rd_stat == PS_BELOW;

    // Signed views of the bounds.
    assign cur_s  = $signed(SW'(r_cur));
    assign low_s  = $signed(SW'(r_low));
    assign high_s = $signed(SW'(r_high));
    assign tot_s  = $signed(SW'(r_tot));

    // Doubling step reaches the upper bound, or lands back on the current count.
    assign t_big   = r_t >= (high_s - ONE_S);
    assign t_eq    = r_t == cur_s;
    assign mid_sel = !r_near && (r_below || t_big);

    // Previous count drops to zero when above the current one.
    assign prev_adj = (r_prev > r_cur) ? '0 : r_prev;

    // Halve the sum when the midpoint is selected, then clamp to 0..total.
    assign next_raw = mid_sel ? $signed({alu_y[SW-1], alu_y[SW-1:1]}) : alu_y;
    always_comb begin
        if (next_raw < ZERO_S) begin
            next_cur = '0;
        end else if (next_raw > tot_s) begin
            next_cur = r_tot;
        end else begin
            next_cur = next_raw[IW-1:0];
        end
    end

    // Shared adder operand selection per sequencer step.
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = cur_s;
        alu_b  = ZERO_S;
        case (r_state)
            S_IDLE: begin
                alu_op = ALU_SUB;
                alu_a  = $signed(SW'(tot_c));
                alu_b  = ONE_S;
            end
            S_READ: begin
                alu_op = ALU_SUB;
                alu_b  = $signed(SW'(r_anchor));
            end
            S_EVAL: begin
                if (hit_full) begin
                    alu_b = ONE_S;
                end else begin
                    alu_op = ALU_SUB;
                    alu_a  = cur_s <<< 1;
                    alu_b  = low_s;
                end
            end
            S_NEXT: begin
                if (r_below && r_near) begin
                    alu_op = ALU_SUB;
                    alu_b  = ONE_S;
                end else if (r_below) begin
                    alu_a = high_s;
                    alu_b = low_s;
                end else if (r_near) begin
                    alu_b = ONE_S;
                end else if (t_big) begin
                    alu_b = high_s;
                end else if (t_eq) begin
                    alu_b = ONE_S;
                end else begin
                    alu_a = r_t;
                end
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.data.command == CMD_START) begin
                        if (tot_c != '0) begin
                            if (r_epoch == EPOCH_LAST) begin
                                n_state = S_SWEEP;
                            end else begin
                                n_state = S_INIT;
                            end
                        end
                    end else if (r_active) begin
                        n_state = S_READ;
                    end
                end
            end
            S_SWEEP: begin
                if (r_sweep_addr == ADDR_LAST) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: n_state = S_IDLE;
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                if (hit_below || hit_full) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath updates, table accesses and results per step.
    always_comb begin
        n_active     = r_active;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_epoch      = r_epoch;
        n_sweep_addr = r_sweep_addr;
        n_later      = r_later;
        n_tot        = r_tot;
        n_full       = r_full;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_low        = r_low;
        n_high       = r_high;
        n_anchor     = r_anchor;
        n_n          = r_n;
        n_below      = r_below;
        n_ahead      = r_ahead;
        n_near       = r_near;
        n_more       = r_more;
        n_t          = r_t;
        n_out        = r_out;
        mem_we       = 1'b0;
        mem_waddr    = r_cur[AW-1:0];
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;

        // Neighbor address for the boundary check.
        if (below_c) begin
            if (r_cur != '0) begin
                mem_raddr = AW'(r_cur - IW'(1));
            end
        end else if (r_cur < r_tot) begin
            mem_raddr = AW'(r_cur + IW'(1));
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.data.command == CMD_START) begin
                        if (tot_c == '0) begin
                            n_active           = 1'b0;
                            n_out_valid        = 1'b1;
                            n_out.status       = STAT_FOUND;
                            n_out.probe_hash   = '0;
                            n_out.result_hash  = '0;
                            n_out.result_count = NSOL_W'(1);
                        end else begin
                            n_tot        = tot_c;
                            n_full       = NSOL_W'(r_threshold) + NSOL_W'(1);
                            n_cur        = start_c;
                            n_prev       = start_c;
                            n_anchor     = start_c;
                            n_low        = '0;
                            n_high       = tot_c;
                            n_later      = i_in.data.later_round;
                            n_active     = 1'b1;
                            n_sweep_addr = '0;
                            if (r_epoch != EPOCH_LAST) begin
                                n_epoch = r_epoch + EPOCH_W'(1);
                            end
                        end
                    end else if (!r_active) begin
                        n_out_valid        = 1'b1;
                        n_out.status       = STAT_IDLE_PROBE;
                        n_out.probe_hash   = '0;
                        n_out.result_hash  = '0;
                        n_out.result_count = '0;
                    end else begin
                        mem_re  = 1'b1;
                        n_n     = sols_c;
                        n_below = below_c;
                        n_ahead = r_cur < r_tot;
                    end
                end
            end
            S_SWEEP: begin
                // Tag zero never matches a live measurement.
                mem_we       = 1'b1;
                mem_waddr    = r_sweep_addr;
                mem_wdata    = '0;
                n_sweep_addr = r_sweep_addr + AW'(1);
                if (r_sweep_addr == ADDR_LAST) begin
                    n_epoch = EPOCH_FIRST;
                end
            end
            S_INIT: begin
                // The total itself always counts as below threshold, count one.
                mem_we             = 1'b1;
                mem_waddr          = r_tot[AW-1:0];
                mem_wdata          = {r_epoch, PS_BELOW, CSW'(1)};
                n_out_valid        = 1'b1;
                n_out.status       = STAT_PROBE;
                n_out.probe_hash   = HASH_W'(r_cur);
                n_out.result_hash  = '0;
                n_out.result_count = '0;
            end
            S_READ: begin
                if (r_below) begin
                    n_near = r_later && (alu_y >= M2_S) && (alu_y <= TWO_S);
                end else begin
                    n_near = r_later && (alu_y >= M1_S) && (alu_y <= ONE_S);
                end
            end
            S_EVAL: begin
                if (hit_below || hit_full) begin
                    n_active          = 1'b0;
                    n_out_valid       = 1'b1;
                    n_out.status      = STAT_FOUND;
                    n_out.probe_hash  = '0;
                    if (hit_below) begin
                        n_out.result_hash  = HASH_W'(r_cur);
                        n_out.result_count = NSOL_W'(r_n[CSW-1:0]);
                    end else begin
                        n_out.result_hash  = HASH_W'(alu_y[IW-1:0]);
                        n_out.result_count = NSOL_W'(rd_cnt);
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cur[AW-1:0];
                    n_t       = alu_y;
                    if (r_below) begin
                        mem_wdata = {r_epoch, PS_BELOW, r_n[CSW-1:0]};
                        n_more    = r_low < r_cur;
                        n_high    = r_cur;
                        if (!r_near) begin
                            n_low = (prev_adj > r_low) ? prev_adj : r_low;
                        end
                    end else begin
                        mem_wdata = {r_epoch, PS_FULL, r_full[CSW-1:0]};
                        n_more    = r_cur < r_high;
                    end
                end
            end
            S_NEXT: begin
                if (!r_below && (r_near || t_big)) begin
                    n_low = r_cur;
                end
                n_prev      = r_cur;
                n_cur       = next_cur;
                n_out_valid = 1'b1;
                n_out.result_hash  = '0;
                n_out.result_count = '0;
                if (r_more) begin
                    n_out.status     = STAT_PROBE;
                    n_out.probe_hash = HASH_W'(next_cur);
                end else begin
                    n_active         = 1'b0;
                    n_out.status     = STAT_EXHAUSTED;
                    n_out.probe_hash = '0;
                end
            end
            default: begin
                n_active = r_active;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_epoch      <= EPOCH_LAST;
            r_total_vars <= TOTAL_RESET;
            r_threshold  <= THR_RESET;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_epoch     <= n_epoch;
            if (cfg_acc) begin
                case (i_cfg.data.reg_index)
                    REG_TOTAL_VARS: r_total_vars <= i_cfg.data.wr_data[TOTAL_W-1:0];
                    REG_THRESHOLD:  r_threshold  <= i_cfg.data.wr_data[THR_W-1:0];
                    default: r_threshold <= r_threshold;
                endcase
            end
        end
    end

    // Search and result payload registers.
    always_ff @(posedge i_clk) begin
        r_sweep_addr <= n_sweep_addr;
        r_later      <= n_later;
        r_tot        <= n_tot;
        r_full       <= n_full;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_low        <= n_low;
        r_high       <= n_high;
        r_anchor     <= n_anchor;
        r_n          <= n_n;
        r_below      <= n_below;
        r_ahead      <= n_ahead;
        r_near       <= n_near;
        r_more       <= n_more;
        r_t          <= n_t;
        r_out        <= n_out;
    end

    // A measurement never runs under the tag that the clearing pass writes.
    a_live_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> (r_epoch != '0))
        else $error("table tag is zero at measurement start");

    // The sequencer leaves idle only on an accepted transaction.
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !in_acc) |=> (r_state == S_IDLE))
        else $error("sequencer left idle without a transaction");

    // The clearing pass runs to its end and then seeds the table.
    a_sweep_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |=> (r_state == S_SWEEP || r_state == S_INIT))
        else $error("clearing pass interrupted");

    // Every requested probe count lies within the latched total.
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_active) |-> (r_cur <= r_tot))
        else $error("probe count beyond total");

endmodule
